>>> hw/rtl/bpsn_pkg.sv
// Shared constants, types and state codes of the band power sigma normalizer.
package bpsn_pkg;

  localparam int unsigned MAX_CHANNELS = 64;
  localparam int unsigned RAM_DEPTH    = MAX_CHANNELS * 4;
  localparam int unsigned RAM_AW       = $clog2(RAM_DEPTH);

  localparam int unsigned CH_W       = 6;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned K_W        = 16;
  localparam int unsigned BCNT_W     = 7;
  localparam int unsigned NORM_W     = 16;
  localparam int unsigned TOT_W      = 22;
  localparam int unsigned KS_W       = K_W + VAL_W;
  localparam int unsigned DIV_W      = KS_W + 1;
  localparam int unsigned NORM_STEPS = 15;
  localparam int unsigned AVG_STEPS  = TOT_W;
  localparam int unsigned QUO_W      = TOT_W;
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned S_TDATA_W  = 136;
  localparam int unsigned S_TUSER_W  = 2;
  localparam int unsigned M_TDATA_W  = 72;

  localparam logic [NORM_W-1:0] ONE_Q15     = 16'd32768;
  localparam logic [NORM_W-1:0] HALF_Q15    = 16'd16384;
  localparam logic [POS_W-1:0]  POS_MAX     = 7'd127;
  localparam logic [K_W-1:0]    K_SIGMA_RST = 16'd512;

  typedef enum logic [0:0] {
    CFG_K_SIGMA    = 1'b0,
    CFG_BASE_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR_MEAN,
    ST_WR_SD,
    ST_RD_MEAN,
    ST_RD_SD,
    ST_MUL,
    ST_TOP,
    ST_SUB,
    ST_CHK,
    ST_DIV,
    ST_ACC,
    ST_AVG_SET,
    ST_AVG_A,
    ST_AVG_B,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] divisor;
    logic             in_bit;
  } step_req_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic             q_bit;
  } step_rsp_t;

endpackage

>>> hw/rtl/bpsn_ram.sv
// Generic single-port RAM with registered read.
module bpsn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/bpsn_div_step.sv
// Shared restoring-division step: shift in one bit, trial subtract, quotient bit.
module bpsn_div_step (
  input  bpsn_pkg::step_req_t req_i,
  output bpsn_pkg::step_rsp_t rsp_o
);

  logic [bpsn_pkg::DIV_W:0] trial;
  logic [bpsn_pkg::DIV_W:0] diff;
  logic                     ge;

  assign trial = {req_i.rem, req_i.in_bit};
  assign diff  = trial - {1'b0, req_i.divisor};
  assign ge    = (trial >= {1'b0, req_i.divisor});

  assign rsp_o.q_bit = ge;
  assign rsp_o.rem   = ge ? diff[bpsn_pkg::DIV_W-1:0] : trial[bpsn_pkg::DIV_W-1:0];

endmodule

>>> hw/rtl/band_power_sigma_normalizer.sv
// Top level: baseline table, sequencer and shared divider of the band power normalizer.
// Load beat: table written in ST_WR_MEAN then ST_WR_SD after accept; then the next beat is taken.
// Sample beat, per band: 2 reads, multiply, 3 checks that may settle the result, 15 divide steps;
// then the sums are accumulated, and at frame end divided for the averages, before the output.
// The output register lets the next beat in while a result waits; one beat is in work.
// Async reset clears sequencer, sums, position, count and registers (k_sigma = 2.0), not table.
module band_power_sigma_normalizer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [0:0]                         cfg_idx_i,
  input  logic [bpsn_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // load_channel, base_mean, base_spread, alpha_power, beta_power, zero pad
  input  logic [bpsn_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // op, band
  input  logic [bpsn_pkg::S_TUSER_W-1:0]     s_axis_tuser,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // channel, alpha_norm, beta_norm, alpha_average, beta_average, zero pad
  output logic [bpsn_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // in_range
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam int unsigned DW = bpsn_pkg::DIV_W;
  localparam int unsigned TW = bpsn_pkg::TOT_W;
  localparam int unsigned NW = bpsn_pkg::NORM_W;
  localparam int unsigned VW = bpsn_pkg::VAL_W;

  bpsn_pkg::state_e                 state_q, state_d;
  logic                             m_valid_q, m_valid_d;
  logic [bpsn_pkg::POS_W-1:0]       pos_q, pos_d;
  logic [bpsn_pkg::BCNT_W-1:0]      counted_q, counted_d;
  logic [TW-1:0]                    atot_q, atot_d, btot_q, btot_d;
  logic [bpsn_pkg::K_W-1:0]         k_sigma_q, k_sigma_d;
  logic [bpsn_pkg::BCNT_W-1:0]      bcount_q, bcount_d;

  logic                             band_in_q, band_in_d;
  logic [bpsn_pkg::CH_W-1:0]        ch_q, ch_d;
  logic [VW-1:0]                    bmean_q, bmean_d, bsd_q, bsd_d;
  logic [VW-1:0]                    alpha_q, alpha_d, beta_q, beta_d;
  logic                             last_q, last_d;
  logic                             ok_q, ok_d;
  logic                             band_q, band_d;
  logic [VW-1:0]                    mean_q, mean_d;
  logic [bpsn_pkg::KS_W-1:0]        ks_q, ks_d;
  logic [DW-1:0]                    top_q, top_d;
  logic [DW-1:0]                    rem_q, rem_d;
  logic [bpsn_pkg::QUO_W-1:0]       quot_q, quot_d;
  logic [TW-1:0]                    dvd_q, dvd_d;
  logic [bpsn_pkg::STEP_W-1:0]      step_q, step_d;
  logic [NW-1:0]                    an_q, an_d, bn_q, bn_d;
  logic [NW-1:0]                    aavg_q, aavg_d, bavg_q, bavg_d;
  logic [bpsn_pkg::M_TDATA_W-1:0]   m_tdata_q, m_tdata_d;
  logic                             m_tuser_q, m_tuser_d;
  logic                             m_tlast_q, m_tlast_d;

  logic                             ram_we;
  logic [bpsn_pkg::RAM_AW-1:0]      ram_addr;
  logic [VW-1:0]                    ram_wdata, ram_rdata;

  bpsn_pkg::step_req_t              step_req;
  bpsn_pkg::step_rsp_t              step_rsp;

  logic [DW-1:0]                    range;
  logic [DW-1:0]                    bot;
  logic [VW-1:0]                    val;
  logic                             sample_ok;
  logic                             load_ok;
  logic                             res_we;
  logic [NW-1:0]                    res_val;

  bpsn_ram #(
    .WIDTH (VW),
    .DEPTH (bpsn_pkg::RAM_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  bpsn_div_step u_step (
    .req_i (step_req),
    .rsp_o (step_rsp)
  );

  assign range     = {ks_q, 1'b0};
  assign bot       = {9'd0, mean_q, 8'd0};
  assign val       = band_q ? beta_q : alpha_q;
  assign sample_ok = (pos_q < bcount_q) && ({25'd0, pos_q} < 32'(bpsn_pkg::MAX_CHANNELS));
  assign load_ok   = ({26'd0, ch_q} < 32'(bpsn_pkg::MAX_CHANNELS));

  assign s_axis_tready = (state_q == bpsn_pkg::ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;
  assign m_axis_tlast  = m_tlast_q;

  always_comb begin
    state_d   = state_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    pos_d     = pos_q;
    counted_d = counted_q;
    atot_d    = atot_q;
    btot_d    = btot_q;
    k_sigma_d = k_sigma_q;
    bcount_d  = bcount_q;
    band_in_d = band_in_q;
    ch_d      = ch_q;
    bmean_d   = bmean_q;
    bsd_d     = bsd_q;
    alpha_d   = alpha_q;
    beta_d    = beta_q;
    last_d    = last_q;
    ok_d      = ok_q;
    band_d    = band_q;
    mean_d    = mean_q;
    ks_d      = ks_q;
    top_d     = top_q;
    rem_d     = rem_q;
    quot_d    = quot_q;
    dvd_d     = dvd_q;
    step_d    = step_q;
    an_d      = an_q;
    bn_d      = bn_q;
    aavg_d    = aavg_q;
    bavg_d    = bavg_q;
    m_tdata_d = m_tdata_q;
    m_tuser_d = m_tuser_q;
    m_tlast_d = m_tlast_q;
    ram_we    = 1'b0;
    ram_addr  = bpsn_pkg::RAM_AW'({pos_q, band_q, 1'b0});
    ram_wdata = bmean_q;
    res_we    = 1'b0;
    res_val   = '0;

    step_req.rem     = rem_q;
    step_req.divisor = range;
    step_req.in_bit  = 1'b0;
    if (state_q == bpsn_pkg::ST_AVG_A || state_q == bpsn_pkg::ST_AVG_B) begin
      step_req.divisor = DW'(counted_q);
      step_req.in_bit  = dvd_q[TW-1];
    end

    if (cfg_we_i) begin
      unique case (bpsn_pkg::cfg_idx_e'(cfg_idx_i))
        bpsn_pkg::CFG_K_SIGMA:    k_sigma_d = cfg_data_i;
        bpsn_pkg::CFG_BASE_COUNT: bcount_d  = cfg_data_i[bpsn_pkg::BCNT_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      bpsn_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          band_in_d = s_axis_tuser[1];
          ch_d      = s_axis_tdata[5:0];
          bmean_d   = s_axis_tdata[37:6];
          bsd_d     = s_axis_tdata[69:38];
          alpha_d   = s_axis_tdata[101:70];
          beta_d    = s_axis_tdata[133:102];
          last_d    = s_axis_tlast;
          ok_d      = sample_ok;
          band_d    = 1'b0;
          an_d      = '0;
          bn_d      = '0;
          aavg_d    = '0;
          bavg_d    = '0;
          if (bpsn_pkg::op_e'(s_axis_tuser[0]) == bpsn_pkg::OP_LOAD) begin
            state_d = bpsn_pkg::ST_WR_MEAN;
          end else if (sample_ok) begin
            state_d = bpsn_pkg::ST_RD_MEAN;
          end else begin
            state_d = bpsn_pkg::ST_ACC;
          end
        end
      end
      bpsn_pkg::ST_WR_MEAN: begin
        ram_we    = load_ok;
        ram_addr  = bpsn_pkg::RAM_AW'({ch_q, band_in_q, 1'b0});
        ram_wdata = bmean_q;
        state_d   = bpsn_pkg::ST_WR_SD;
      end
      bpsn_pkg::ST_WR_SD: begin
        ram_we    = load_ok;
        ram_addr  = bpsn_pkg::RAM_AW'({ch_q, band_in_q, 1'b1});
        ram_wdata = bsd_q;
        state_d   = bpsn_pkg::ST_IDLE;
      end
      bpsn_pkg::ST_RD_MEAN: begin
        state_d = bpsn_pkg::ST_RD_SD;
      end
      bpsn_pkg::ST_RD_SD: begin
        ram_addr = bpsn_pkg::RAM_AW'({pos_q, band_q, 1'b1});
        mean_d   = ram_rdata;
        state_d  = bpsn_pkg::ST_MUL;
      end
      bpsn_pkg::ST_MUL: begin
        ks_d    = k_sigma_q * ram_rdata;
        state_d = bpsn_pkg::ST_TOP;
      end
      bpsn_pkg::ST_TOP: begin
        if (ks_q == '0) begin
          res_we  = 1'b1;
          res_val = bpsn_pkg::HALF_Q15;
        end else begin
          top_d   = {9'd0, val, 8'd0} + {1'b0, ks_q};
          state_d = bpsn_pkg::ST_SUB;
        end
      end
      bpsn_pkg::ST_SUB: begin
        if (top_q <= bot) begin
          res_we  = 1'b1;
          res_val = '0;
        end else begin
          rem_d   = top_q - bot;
          state_d = bpsn_pkg::ST_CHK;
        end
      end
      bpsn_pkg::ST_CHK: begin
        if (rem_q >= range) begin
          res_we  = 1'b1;
          res_val = bpsn_pkg::ONE_Q15;
        end else begin
          quot_d  = '0;
          step_d  = '0;
          state_d = bpsn_pkg::ST_DIV;
        end
      end
      bpsn_pkg::ST_DIV: begin
        rem_d  = step_rsp.rem;
        quot_d = {quot_q[bpsn_pkg::QUO_W-2:0], step_rsp.q_bit};
        step_d = step_q + 1'b1;
        if (step_q == bpsn_pkg::STEP_W'(bpsn_pkg::NORM_STEPS - 1)) begin
          res_we  = 1'b1;
          res_val = quot_d[NW-1:0];
        end
      end
      bpsn_pkg::ST_ACC: begin
        if (ok_q) begin
          atot_d    = atot_q + TW'(an_q);
          btot_d    = btot_q + TW'(bn_q);
          counted_d = counted_q + 1'b1;
        end
        state_d = bpsn_pkg::ST_AVG_SET;
      end
      bpsn_pkg::ST_AVG_SET: begin
        if (last_q && counted_q != '0) begin
          rem_d   = '0;
          dvd_d   = atot_q;
          step_d  = '0;
          state_d = bpsn_pkg::ST_AVG_A;
        end else begin
          state_d = bpsn_pkg::ST_OUT;
        end
      end
      bpsn_pkg::ST_AVG_A: begin
        rem_d  = step_rsp.rem;
        quot_d = {quot_q[bpsn_pkg::QUO_W-2:0], step_rsp.q_bit};
        dvd_d  = {dvd_q[TW-2:0], 1'b0};
        step_d = step_q + 1'b1;
        if (step_q == bpsn_pkg::STEP_W'(bpsn_pkg::AVG_STEPS - 1)) begin
          aavg_d  = quot_d[NW-1:0];
          rem_d   = '0;
          dvd_d   = btot_q;
          step_d  = '0;
          state_d = bpsn_pkg::ST_AVG_B;
        end
      end
      bpsn_pkg::ST_AVG_B: begin
        rem_d  = step_rsp.rem;
        quot_d = {quot_q[bpsn_pkg::QUO_W-2:0], step_rsp.q_bit};
        dvd_d  = {dvd_q[TW-2:0], 1'b0};
        step_d = step_q + 1'b1;
        if (step_q == bpsn_pkg::STEP_W'(bpsn_pkg::AVG_STEPS - 1)) begin
          bavg_d  = quot_d[NW-1:0];
          state_d = bpsn_pkg::ST_OUT;
        end
      end
      bpsn_pkg::ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_tdata_d = {2'b00, bavg_q, aavg_q, bn_q, an_q, pos_q[bpsn_pkg::CH_W-1:0]};
          m_tuser_d = ok_q;
          m_tlast_d = last_q;
          if (last_q) begin
            atot_d    = '0;
            btot_d    = '0;
            pos_d     = '0;
            counted_d = '0;
          end else if (pos_q < bpsn_pkg::POS_MAX) begin
            pos_d = pos_q + 1'b1;
          end
          state_d = bpsn_pkg::ST_IDLE;
        end
      end
      default: state_d = bpsn_pkg::ST_IDLE;
    endcase

    if (res_we) begin
      if (band_q) begin
        bn_d    = res_val;
        state_d = bpsn_pkg::ST_ACC;
      end else begin
        an_d    = res_val;
        band_d  = 1'b1;
        state_d = bpsn_pkg::ST_RD_MEAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bpsn_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
      pos_q     <= '0;
      counted_q <= '0;
      atot_q    <= '0;
      btot_q    <= '0;
      k_sigma_q <= bpsn_pkg::K_SIGMA_RST;
      bcount_q  <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      pos_q     <= pos_d;
      counted_q <= counted_d;
      atot_q    <= atot_d;
      btot_q    <= btot_d;
      k_sigma_q <= k_sigma_d;
      bcount_q  <= bcount_d;
    end
  end

  always_ff @(posedge clk_i) begin
    band_in_q <= band_in_d;
    ch_q      <= ch_d;
    bmean_q   <= bmean_d;
    bsd_q     <= bsd_d;
    alpha_q   <= alpha_d;
    beta_q    <= beta_d;
    last_q    <= last_d;
    ok_q      <= ok_d;
    band_q    <= band_d;
    mean_q    <= mean_d;
    ks_q      <= ks_d;
    top_q     <= top_d;
    rem_q     <= rem_d;
    quot_q    <= quot_d;
    dvd_q     <= dvd_d;
    step_q    <= step_d;
    an_q      <= an_d;
    bn_q      <= bn_d;
    aavg_q    <= aavg_d;
    bavg_q    <= bavg_d;
    m_tdata_q <= m_tdata_d;
    m_tuser_q <= m_tuser_d;
    m_tlast_q <= m_tlast_d;
  end

endmodule
